// File: hdl/sfr_pkg.sv
// Package for the serial frame receiver: codes, reset values, state and result types.
// Used by the result channel interface, the step logic and the top level. No dependencies.
`default_nettype none

package sfr_pkg;

  localparam int unsigned PADDR_W = 3;

  localparam logic [7:0]  START_BYTE  = 8'h01;
  localparam logic [7:0]  ACK_BYTE    = 8'h06;
  localparam logic [7:0]  NAK_BYTE    = 8'h15;
  localparam logic [7:0]  XOR_SEED    = 8'hFF;
  localparam logic [7:0]  MIN_LEN     = 8'd3;
  localparam logic [8:0]  MAX_LEN_RST = 9'd256;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;

  localparam logic REG_MAX_LEN = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_CSUM_BAD = 3'd2,
    KIND_LEN_BAD  = 3'd3,
    KIND_TIMEOUT  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0]  phase;
    logic [7:0]  bytes_left;
    logic [8:0]  position;
    logic [7:0]  running_xor;
    logic [15:0] idle_count;
  } st_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [8:0] byte_index;
    logic       control_valid;
    logic [7:0] control_byte;
  } res_t;

  function automatic st_t hunt_state();
    st_t s;
    s.phase       = PH_HUNT;
    s.bytes_left  = 8'd0;
    s.position    = 9'd0;
    s.running_xor = XOR_SEED;
    s.idle_count  = 16'd0;
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hdl/sfr_in_if.sv
// Input channel of the serial frame receiver: received byte or time tick per beat.
// Stand-alone; no package needed.
`default_nettype none

interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, operation, rx_byte, input ready);
  modport sink   (input valid, operation, rx_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/sfr_out_if.sv
// Result channel of the serial frame receiver: one frame byte or verdict per beat.
// Depends on sfr_pkg for the kind codes.
`default_nettype none

interface sfr_out_if;
  logic               valid;
  logic               ready;
  sfr_pkg::kind_e     kind;
  logic [7:0]         data_byte;
  logic [8:0]         byte_index;
  logic               control_valid;
  logic [7:0]         control_byte;

  modport source (output valid, kind, data_byte, byte_index, control_valid, control_byte,
                  input ready);
  modport sink   (input valid, kind, data_byte, byte_index, control_valid, control_byte,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/sfr_step.sv
// Next-state and result logic of the frame receiver for one byte or tick.
// Depends on sfr_pkg for the state and result types and the protocol constants.
`default_nettype none

module sfr_step (
  input  var sfr_pkg::st_t  st_i,
  input  wire               operation_i,
  input  wire  [7:0]        rx_byte_i,
  input  wire  [8:0]        max_frame_len_i,
  input  wire  [15:0]       timeout_ticks_i,
  output sfr_pkg::st_t      st_o,
  output logic              res_valid_o,
  output sfr_pkg::res_t     res_o
);

  logic [15:0] limit;
  logic [16:0] idle_inc;
  logic [9:0]  total_len;

  assign limit     = (timeout_ticks_i == 16'd0) ? 16'd1 : timeout_ticks_i;
  assign idle_inc  = {1'b0, st_i.idle_count} + 17'd1;
  assign total_len = {2'b00, rx_byte_i} + 10'd2;

  always_comb begin
    st_o        = st_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = sfr_pkg::KIND_BYTE;
    if (operation_i) begin
      if (st_i.phase != sfr_pkg::PH_HUNT) begin
        if (idle_inc >= {1'b0, limit}) begin
          st_o        = sfr_pkg::hunt_state();
          res_valid_o = 1'b1;
          res_o.kind  = sfr_pkg::KIND_TIMEOUT;
        end else begin
          st_o.idle_count = idle_inc[15:0];
        end
      end
    end else begin
      unique case (st_i.phase)
        sfr_pkg::PH_HUNT: begin
          if (rx_byte_i == sfr_pkg::START_BYTE) begin
            st_o.phase       = sfr_pkg::PH_LEN;
            st_o.position    = 9'd0;
            st_o.running_xor = sfr_pkg::XOR_SEED;
            st_o.idle_count  = 16'd0;
          end
        end
        sfr_pkg::PH_LEN: begin
          res_valid_o = 1'b1;
          if (rx_byte_i < sfr_pkg::MIN_LEN || total_len > {1'b0, max_frame_len_i}) begin
            st_o                = sfr_pkg::hunt_state();
            res_o.kind          = sfr_pkg::KIND_LEN_BAD;
            res_o.control_valid = 1'b1;
            res_o.control_byte  = sfr_pkg::NAK_BYTE;
          end else begin
            st_o.phase       = sfr_pkg::PH_BODY;
            st_o.bytes_left  = rx_byte_i;
            st_o.position    = 9'd1;
            st_o.running_xor = st_i.running_xor ^ rx_byte_i;
            st_o.idle_count  = 16'd0;
            res_o.data_byte  = rx_byte_i;
            res_o.byte_index = 9'd1;
          end
        end
        sfr_pkg::PH_BODY: begin
          res_valid_o = 1'b1;
          if (st_i.bytes_left <= 8'd1) begin
            st_o                = sfr_pkg::hunt_state();
            res_o.control_valid = 1'b1;
            if (st_i.running_xor == rx_byte_i) begin
              res_o.kind         = sfr_pkg::KIND_GOOD;
              res_o.byte_index   = st_i.position + 9'd2;
              res_o.control_byte = sfr_pkg::ACK_BYTE;
            end else begin
              res_o.kind         = sfr_pkg::KIND_CSUM_BAD;
              res_o.control_byte = sfr_pkg::NAK_BYTE;
            end
          end else begin
            st_o.running_xor = st_i.running_xor ^ rx_byte_i;
            st_o.position    = st_i.position + 9'd1;
            st_o.bytes_left  = st_i.bytes_left - 8'd1;
            st_o.idle_count  = 16'd0;
            res_o.data_byte  = rx_byte_i;
            res_o.byte_index = st_i.position + 9'd1;
          end
        end
        default: begin
          st_o = sfr_pkg::hunt_state();
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/serial_frame_receiver_xor_ack.sv
// Top level of the serial frame receiver: input register, step logic, result register, APB.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if and sfr_step.
//
//   channel   direction  beat
//   in_i      sink       operation (0 byte, 1 tick), rx_byte
//   out_o     source     kind, data_byte, byte_index, control_valid, control_byte
//   APB       slave      max_frame_len at 0x0, timeout_ticks at 0x4
//
// Each beat passes through the input register and then the result register, so a result is
// offered from the result register, and one beat enters per cycle unless a stalled result fills both.
// Reset returns the receiver to hunting and the registers to 256 and 1000.
// A stalled result holds the input register; the input side stalls only when both are full.
`default_nettype none

module serial_frame_receiver_xor_ack (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  sfr_in_if.sink                       in_i,
  sfr_out_if.source                    out_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [sfr_pkg::PADDR_W-1:0]  paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [8:0]    max_len_q;
  logic [15:0]   timeout_q;
  logic          cfg_wr;

  logic          s1_valid_q;
  logic          s1_op_q;
  logic [7:0]    s1_byte_q;
  logic          advance;
  logic          in_fire;
  logic          s1_fire;

  sfr_pkg::st_t  st_q;
  sfr_pkg::st_t  st_d;
  logic          res_valid;
  sfr_pkg::res_t res;

  logic          out_valid_q;
  sfr_pkg::res_t out_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= sfr_pkg::MAX_LEN_RST;
      timeout_q <= sfr_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        sfr_pkg::REG_MAX_LEN: max_len_q <= pwdata[8:0];
        sfr_pkg::REG_TIMEOUT: timeout_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sfr_pkg::REG_MAX_LEN: prdata = {23'd0, max_len_q};
      sfr_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_q};
      default:              prdata = 32'd0;
    endcase
  end

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;
  assign s1_fire    = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= in_i.operation;
      s1_byte_q <= in_i.rx_byte;
    end
  end

  sfr_step u_step (
    .st_i            (st_q),
    .operation_i     (s1_op_q),
    .rx_byte_i       (s1_byte_q),
    .max_frame_len_i (max_len_q),
    .timeout_ticks_i (timeout_q),
    .st_o            (st_d),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= sfr_pkg::hunt_state();
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q && res_valid;
      if (s1_valid_q) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = out_q.kind;
  assign out_o.data_byte     = out_q.data_byte;
  assign out_o.byte_index    = out_q.byte_index;
  assign out_o.control_valid = out_q.control_valid;
  assign out_o.control_byte  = out_q.control_byte;

  a_hunt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == sfr_pkg::PH_HUNT |->
      st_q.position == 9'd0 && st_q.running_xor == sfr_pkg::XOR_SEED &&
      st_q.idle_count == 16'd0)
    else $error("hunting state not cleared");

  a_body_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == sfr_pkg::PH_BODY |-> st_q.bytes_left != 8'd0 && st_q.position != 9'd0)
    else $error("body phase without bytes due");

  a_abort_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && res_valid && res.kind != sfr_pkg::KIND_BYTE |=>
      st_q.phase == sfr_pkg::PH_HUNT)
    else $error("verdict did not return to hunting");

  a_control_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |->
      out_q.control_valid == (out_q.kind == sfr_pkg::KIND_GOOD ||
                              out_q.kind == sfr_pkg::KIND_CSUM_BAD ||
                              out_q.kind == sfr_pkg::KIND_LEN_BAD))
    else $error("control byte flag does not match result kind");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for serial_frame_receiver_xor_ack: sends received bytes and ticks, sets both
// registers over APB, and checks each result beat against a built-in frame predictor.
// Depends on sfr_pkg, sfr_in_if, sfr_out_if and the receiver RTL.

module testbench;
  import sfr_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 150;
  localparam logic [PADDR_W-1:0] ADDR_MAX_LEN = {REG_MAX_LEN, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_TIMEOUT = {REG_TIMEOUT, 2'b00};

  class frame_scoreboard;
    logic [8:0]  max_len;
    logic [15:0] tick_limit;
    logic [1:0]  rx_phase;
    logic [7:0]  body_left;
    logic [8:0]  frame_pos;
    logic [7:0]  csum;
    int unsigned idle_ticks;
    res_t        results_due[$];
    int          mismatches;

    function new();
      max_len    = MAX_LEN_RST;
      tick_limit = TIMEOUT_RST;
      mismatches = 0;
      rehunt();
    endfunction

    function void rehunt();
      rx_phase   = PH_HUNT;
      body_left  = 8'd0;
      frame_pos  = 9'd0;
      csum       = XOR_SEED;
      idle_ticks = 0;
    endfunction

    function bit take_rx_beat(logic is_tick, logic [7:0] b);
      res_t        r;
      int unsigned eff;
      logic [8:0]  total;
      r.kind          = KIND_BYTE;
      r.data_byte     = 8'd0;
      r.byte_index    = 9'd0;
      r.control_valid = 1'b0;
      r.control_byte  = 8'd0;
      if (is_tick) begin
        if (rx_phase == PH_HUNT) return 1'b0;
        eff = (tick_limit == 16'd0) ? 1 : tick_limit;
        idle_ticks++;
        if (idle_ticks < eff) return 1'b0;
        rehunt();
        r.kind = KIND_TIMEOUT;
      end else if (rx_phase == PH_HUNT) begin
        if (b == START_BYTE) begin
          rx_phase   = PH_LEN;
          frame_pos  = 9'd0;
          csum       = XOR_SEED;
          idle_ticks = 0;
        end
        return 1'b0;
      end else if (rx_phase == PH_LEN) begin
        idle_ticks = 0;
        if (b < MIN_LEN || int'(b) + 2 > int'(max_len)) begin
          rehunt();
          r.kind          = KIND_LEN_BAD;
          r.control_valid = 1'b1;
          r.control_byte  = NAK_BYTE;
        end else begin
          csum         = csum ^ b;
          body_left    = b;
          frame_pos    = 9'd1;
          rx_phase     = PH_BODY;
          r.data_byte  = b;
          r.byte_index = 9'd1;
        end
      end else if (body_left <= 8'd1) begin
        total = frame_pos + 9'd2;
        r.control_valid = 1'b1;
        if (csum == b) begin
          r.kind         = KIND_GOOD;
          r.byte_index   = total;
          r.control_byte = ACK_BYTE;
        end else begin
          r.kind         = KIND_CSUM_BAD;
          r.control_byte = NAK_BYTE;
        end
        rehunt();
      end else begin
        idle_ticks   = 0;
        csum         = csum ^ b;
        frame_pos    = frame_pos + 9'd1;
        body_left    = body_left - 8'd1;
        r.data_byte  = b;
        r.byte_index = frame_pos;
      end
      results_due.push_back(r);
      return 1'b1;
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task match_out_beat(res_t got);
      res_t want;
      if (results_due.size() == 0) begin
        report($sformatf("result beat with nothing due, kind %0d", got.kind));
        return;
      end
      want = results_due.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.data_byte !== want.data_byte)
        report($sformatf("data_byte %h, want %h", got.data_byte, want.data_byte));
      if (got.byte_index !== want.byte_index)
        report($sformatf("byte_index %0d, want %0d", got.byte_index, want.byte_index));
      if (got.control_valid !== want.control_valid)
        report($sformatf("control_valid %b, want %b", got.control_valid, want.control_valid));
      if (got.control_byte !== want.control_byte)
        report($sformatf("control_byte %h, want %h", got.control_byte, want.control_byte));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  wire  [31:0]         prdata;
  wire                 pready;

  sfr_in_if  in_if ();
  sfr_out_if out_if ();

  serial_frame_receiver_xor_ack DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  frame_scoreboard sb = new();
  bit tx_idle_on   = 1'b1;
  bit rx_idle_on   = 1'b1;
  bit hold_req     = 1'b0;
  int framed_beats = 0;
  int cycle_count  = 0;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    res_t        seen;
    stall_left = 0;
    hold_left  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        seen.kind          = out_if.kind;
        seen.data_byte     = out_if.data_byte;
        seen.byte_index    = out_if.byte_index;
        seen.control_valid = out_if.control_valid;
        seen.control_byte  = out_if.control_byte;
        sb.match_out_beat(seen);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_beat(logic is_tick, logic [7:0] b);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= is_tick;
    in_if.rx_byte   <= b;
    do @(posedge clk_i); while (!in_if.ready);
    if (sb.take_rx_beat(is_tick, b)) framed_beats++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_beat(1'b0, b);
  endtask

  task automatic send_tick();
    send_beat(1'b1, 8'($urandom));
  endtask

  task automatic maybe_ticks();
    int eff;
    eff = (sb.tick_limit == 16'd0) ? 1 : int'(sb.tick_limit);
    if (eff > 1 && $urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, (eff - 1 > 3) ? 3 : eff - 1)) send_tick();
  endtask

  task automatic send_frame(input logic [7:0] body[$], input bit bad_csum);
    logic [7:0] len;
    logic [7:0] sum;
    len = 8'(body.size() + 1);
    sum = XOR_SEED ^ len;
    send_byte(START_BYTE);
    maybe_ticks();
    send_byte(len);
    foreach (body[i]) begin
      maybe_ticks();
      send_byte(body[i]);
      sum = sum ^ body[i];
    end
    if (bad_csum) sum = sum ^ 8'($urandom_range(1, 255));
    maybe_ticks();
    send_byte(sum);
  endtask

  task automatic resync();
    while (sb.rx_phase != PH_HUNT) send_byte(8'h00);
  endtask

  task automatic random_sequence();
    int         hi;
    int         len;
    int         pick;
    int         eff;
    logic [7:0] body[$];
    hi = int'(sb.max_len) - 2;
    if (hi > 255) hi = 255;
    eff = (sb.tick_limit == 16'd0) ? 1 : int'(sb.tick_limit);
    pick = $urandom_range(0, 99);
    if (pick < 65 && hi >= 3) begin
      resync();
      if ($urandom_range(0, 19) == 0) len = hi;
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(3, hi);
      else len = $urandom_range(3, (hi < 12) ? hi : 12);
      body = {};
      repeat (len - 1) body.push_back(8'($urandom));
      send_frame(body, $urandom_range(0, 6) == 0);
    end else if (pick < 77) begin
      resync();
      send_byte(START_BYTE);
      if (hi < 3) len = $urandom_range(0, 255);
      else if (hi < 255 && $urandom_range(0, 1)) len = $urandom_range(hi + 1, 255);
      else len = $urandom_range(0, 2);
      send_byte(8'(len));
    end else if (pick < 85 && eff <= 64) begin
      resync();
      send_byte(START_BYTE);
      if (hi >= 3 && $urandom_range(0, 1)) begin
        len = $urandom_range(3, (hi < 12) ? hi : 12);
        send_byte(8'(len));
        repeat ($urandom_range(0, len - 2)) send_byte(8'($urandom));
      end
      while (sb.rx_phase != PH_HUNT) send_tick();
    end else if (pick < 93) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1)) send_tick();
        else send_byte(8'($urandom));
      end
    end else begin
      send_byte(START_BYTE);
      send_byte(8'($urandom));
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_MAX_LEN) sb.max_len = data[8:0];
    else sb.tick_limit = data[15:0];
    @(posedge clk_i);
  endtask

  task automatic run_phase(logic [8:0] max_len, logic [15:0] ticks, int quota);
    int stop_at;
    wait_drained();
    repeat (4) @(posedge clk_i);
    write_reg(ADDR_MAX_LEN, 32'(max_len));
    write_reg(ADDR_TIMEOUT, 32'(ticks));
    stop_at = framed_beats + quota;
    while (framed_beats < stop_at) random_sequence();
  endtask

  initial begin
    logic [7:0] body[$];
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.operation <= 1'b0;
    in_if.rx_byte   <= 8'h00;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= 32'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00);
    send_tick();
    send_byte(8'hFF);
    send_frame({START_BYTE, 8'hFF}, 1'b0);
    send_frame({8'h00, 8'h80}, 1'b1);
    send_byte(START_BYTE);
    send_byte(8'h00);
    send_byte(START_BYTE);
    send_byte(8'h02);
    send_byte(START_BYTE);
    send_byte(8'hFF);
    send_byte(START_BYTE);
    send_tick();
    send_byte(8'h03);
    send_tick();
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(XOR_SEED ^ 8'h03 ^ 8'h55 ^ 8'hAA);

    hold_req = 1'b1;
    body = {};
    repeat (199) body.push_back(8'($urandom));
    send_frame(body, 1'b0);

    run_phase(9'd5, 16'd1, 90);
    run_phase(9'd511, 16'd0, 90);
    run_phase(9'd0, 16'd3, 40);
    run_phase(9'd300, 16'd65535, 90);
    resync();
    send_byte(START_BYTE);
    send_byte(8'd20);
    send_byte(8'h5A);
    repeat (40) send_tick();
    resync();
    run_phase(MAX_LEN_RST, TIMEOUT_RST, 90);
    run_phase(9'($urandom_range(5, 256)), 16'($urandom_range(2, 64)), 90);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_phase(9'($urandom_range(5, 256)), 16'($urandom_range(1, 64)), 70);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
